/* hw/rtl/sffc_pkg.sv */
// Small float format converter: shared types and constants.
// Used by the channel interfaces and the converter top level.
package sffc_pkg;

  localparam int unsigned KIND_W = 3;
  localparam int unsigned WORD_W = 32;

  typedef enum logic [KIND_W-1:0] {
    K_TO_F16    = 3'd0,
    K_FROM_F16  = 3'd1,
    K_TO_BF16   = 3'd2,
    K_FROM_BF16 = 3'd3,
    K_TO_E4M3   = 3'd4,
    K_FROM_E4M3 = 3'd5,
    K_TO_E5M2   = 3'd6,
    K_FROM_E5M2 = 3'd7
  } kind_t;

  // result class for stage 3 packing
  typedef enum logic [1:0] {
    CLS_FIN  = 2'd0,
    CLS_ZERO = 2'd1,
    CLS_OVF  = 2'd2,
    CLS_NAN  = 2'd3
  } cls_t;

  localparam logic [14:0] F16_INF     = 15'h7C00;
  localparam logic [6:0]  E4M3_SAT    = 7'h7F;
  localparam logic [6:0]  E5M2_INF    = 7'h7C;
  localparam logic [31:0] BF16_BIAS   = 32'h0000_7FFF;
  localparam logic [7:0]  F32_EXP_MAX = 8'hFF;
  localparam logic [7:0]  F16_BIAS_D  = 8'd112;
  localparam logic [7:0]  E4M3_BIAS_D = 8'd120;

  // stage 1: raw word plus compares, bf16 rounding add, fp16 subnormal lzc
  typedef struct packed {
    kind_t       kind;
    logic [31:0] op;
    logic        e_le112;
    logic        e_ge143;
    logic        e_le120;
    logic        e_ge135;
    logic        e_ff;
    logic        m_nz;
    logic [15:0] bf_hi;
    logic [3:0]  lz;
  } s1_t;

  // stage 2: sign, class, exponent and mantissa fields
  typedef struct packed {
    kind_t       kind;
    logic        sign;
    cls_t        cls;
    logic [7:0]  exp;
    logic [22:0] man;
  } s2_t;

endpackage

/* hw/rtl/sffc_req_if.sv */
// Request channel: conversion kind and source bit pattern.
// Depends on sffc_pkg for field widths.
interface sffc_req_if;
  logic                          valid;
  logic                          ready;
  logic [sffc_pkg::KIND_W-1:0]   kind;
  logic [sffc_pkg::WORD_W-1:0]   operand_bits;

  modport source (output valid, kind, operand_bits, input ready);
  modport sink   (input valid, kind, operand_bits, output ready);
endinterface

/* hw/rtl/sffc_rsp_if.sv */
// Response channel: converted bit pattern.
// Depends on sffc_pkg for field widths.
interface sffc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [sffc_pkg::WORD_W-1:0]   result_bits;

  modport source (output valid, result_bits, input ready);
  modport sink   (input valid, result_bits, output ready);
endinterface

/* hw/rtl/small_float_format_converter.sv */
// Small float format converter top level: three-stage conversion pipeline.
// Depends on sffc_pkg, sffc_req_if and sffc_rsp_if.
//
// Converts binary32 to and from binary16, bfloat16, FP8 E4M3 and FP8 E5M2.
// One word is taken per cycle while the response channel does not hold the pipe.
// Each result is presented on the response channel from the last of the three
// register stages (field compares and rounding add, exponent arithmetic, result
// packing) and leaves when ready is high. Each stage holds only when the stage
// after it is full and itself held, so back-pressure on the response channel
// stalls the pipe without loss; up to three words are in flight. Narrow fields
// sit in the low bits of the 32-bit words.
module small_float_format_converter (
  input  logic      clk,
  input  logic      rst,
  sffc_req_if.sink  req,
  sffc_rsp_if.source rsp
);

  sffc_pkg::s1_t s1, s1_next;
  sffc_pkg::s2_t s2, s2_next;
  logic [31:0]   s3, s3_next;
  logic          v1, v2, v3;
  logic          rdy1, rdy2, rdy3;

  assign rdy3      = !v3 || rsp.ready;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign req.ready = rdy1;
  assign rsp.valid = v3;
  assign rsp.result_bits = s3;

  // stage 1
  always_comb begin
    logic [7:0]  e;
    logic [31:0] sum;
    e   = req.operand_bits[30:23];
    sum = req.operand_bits + sffc_pkg::BF16_BIAS + {31'b0, req.operand_bits[16]};
    s1_next.kind    = sffc_pkg::kind_t'(req.kind);
    s1_next.op      = req.operand_bits;
    s1_next.e_le112 = (e <= 8'd112);
    s1_next.e_ge143 = (e >= 8'd143);
    s1_next.e_le120 = (e <= 8'd120);
    s1_next.e_ge135 = (e >= 8'd135);
    s1_next.e_ff    = (e == sffc_pkg::F32_EXP_MAX);
    s1_next.m_nz    = |req.operand_bits[22:0];
    s1_next.bf_hi   = sum[31:16];
    s1_next.lz      = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (req.operand_bits[i]) s1_next.lz = 4'(9 - i);
    end
  end

  // stage 2
  always_comb begin
    logic [7:0]  e32;
    logic [4:0]  e5h;
    logic [3:0]  e4;
    logic [4:0]  e5;
    logic [10:0] sub_sh;
    e32    = s1.op[30:23];
    e5h    = s1.op[14:10];
    e4     = s1.op[6:3];
    e5     = s1.op[6:2];
    sub_sh = {s1.op[9:0], 1'b0} << s1.lz;
    s2_next.kind = s1.kind;
    s2_next.sign = s1.op[31];
    s2_next.cls  = sffc_pkg::CLS_FIN;
    s2_next.exp  = 8'd0;
    s2_next.man  = 23'd0;
    unique case (s1.kind)
      sffc_pkg::K_TO_F16: begin
        s2_next.exp = e32 - sffc_pkg::F16_BIAS_D;
        s2_next.man = {13'b0, s1.op[22:13]};
        if (s1.e_ff) begin
          s2_next.cls = sffc_pkg::CLS_NAN;
          s2_next.man = {22'b0, s1.m_nz};
        end else if (s1.e_le112) begin
          s2_next.cls = sffc_pkg::CLS_ZERO;
        end else if (s1.e_ge143) begin
          s2_next.cls = sffc_pkg::CLS_OVF;
        end
      end
      sffc_pkg::K_FROM_F16: begin
        s2_next.sign = s1.op[15];
        if (e5h == 5'h1F) begin
          s2_next.exp = sffc_pkg::F32_EXP_MAX;
          s2_next.man = {s1.op[9:0], 13'b0};
        end else if (e5h == 5'd0) begin
          if (s1.op[9:0] == 10'd0) s2_next.cls = sffc_pkg::CLS_ZERO;
          s2_next.exp = sffc_pkg::F16_BIAS_D - {4'b0, s1.lz};
          s2_next.man = {sub_sh[9:0], 13'b0};
        end else begin
          s2_next.exp = {3'b0, e5h} + sffc_pkg::F16_BIAS_D;
          s2_next.man = {s1.op[9:0], 13'b0};
        end
      end
      sffc_pkg::K_TO_BF16: begin
        s2_next.sign = 1'b0;
        s2_next.man  = {7'b0, s1.bf_hi};
      end
      sffc_pkg::K_FROM_BF16: begin
        s2_next.sign = 1'b0;
        s2_next.man  = {7'b0, s1.op[15:0]};
      end
      sffc_pkg::K_TO_E4M3: begin
        s2_next.exp = e32 - sffc_pkg::E4M3_BIAS_D;
        s2_next.man = {20'b0, s1.op[22:20]};
        if (s1.e_le120)      s2_next.cls = sffc_pkg::CLS_ZERO;
        else if (s1.e_ge135) s2_next.cls = sffc_pkg::CLS_OVF;
      end
      sffc_pkg::K_FROM_E4M3: begin
        s2_next.sign = s1.op[7];
        s2_next.man  = {s1.op[2:0], 20'b0};
        if (e4 == 4'd0) begin
          if (s1.op[2:0] == 3'd0) s2_next.cls = sffc_pkg::CLS_ZERO;
          s2_next.exp = sffc_pkg::E4M3_BIAS_D + 8'd1;
        end else begin
          s2_next.exp = {4'b0, e4} + sffc_pkg::E4M3_BIAS_D;
        end
      end
      sffc_pkg::K_TO_E5M2: begin
        s2_next.exp = e32 - sffc_pkg::F16_BIAS_D;
        s2_next.man = {21'b0, s1.op[22:21]};
        if (s1.e_le112)      s2_next.cls = sffc_pkg::CLS_ZERO;
        else if (s1.e_ge143) s2_next.cls = sffc_pkg::CLS_OVF;
      end
      sffc_pkg::K_FROM_E5M2: begin
        s2_next.sign = s1.op[7];
        s2_next.man  = {s1.op[1:0], 21'b0};
        if (e5 == 5'h1F) begin
          s2_next.exp = sffc_pkg::F32_EXP_MAX;
        end else if (e5 == 5'd0) begin
          s2_next.cls = sffc_pkg::CLS_ZERO;
        end else begin
          s2_next.exp = {3'b0, e5} + sffc_pkg::F16_BIAS_D;
        end
      end
    endcase
  end

  // stage 3: pack
  always_comb begin
    s3_next = 32'd0;
    unique case (s2.kind)
      sffc_pkg::K_TO_F16: begin
        case (s2.cls)
          sffc_pkg::CLS_ZERO: s3_next = {16'b0, s2.sign, 15'b0};
          sffc_pkg::CLS_OVF:  s3_next = {16'b0, s2.sign, sffc_pkg::F16_INF};
          sffc_pkg::CLS_NAN:  s3_next = {16'b0, s2.sign, sffc_pkg::F16_INF[14:1], s2.man[0]};
          default:            s3_next = {16'b0, s2.sign, s2.exp[4:0], s2.man[9:0]};
        endcase
      end
      sffc_pkg::K_TO_BF16:   s3_next = {16'b0, s2.man[15:0]};
      sffc_pkg::K_FROM_BF16: s3_next = {s2.man[15:0], 16'b0};
      sffc_pkg::K_TO_E4M3: begin
        case (s2.cls)
          sffc_pkg::CLS_ZERO: s3_next = {24'b0, s2.sign, 7'b0};
          sffc_pkg::CLS_OVF:  s3_next = {24'b0, s2.sign, sffc_pkg::E4M3_SAT};
          default:            s3_next = {24'b0, s2.sign, s2.exp[3:0], s2.man[2:0]};
        endcase
      end
      sffc_pkg::K_TO_E5M2: begin
        case (s2.cls)
          sffc_pkg::CLS_ZERO: s3_next = {24'b0, s2.sign, 7'b0};
          sffc_pkg::CLS_OVF:  s3_next = {24'b0, s2.sign, sffc_pkg::E5M2_INF};
          default:            s3_next = {24'b0, s2.sign, s2.exp[4:0], s2.man[1:0]};
        endcase
      end
      sffc_pkg::K_FROM_F16, sffc_pkg::K_FROM_E4M3, sffc_pkg::K_FROM_E5M2: begin
        if (s2.cls == sffc_pkg::CLS_ZERO) s3_next = {s2.sign, 31'b0};
        else                              s3_next = {s2.sign, s2.exp, s2.man};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= req.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1 <= s1_next;
    if (rdy2) s2 <= s2_next;
    if (rdy3) s3 <= s3_next;
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (v1 && v2 && v3 && !rsp.ready))
    else $error("input stalled while the pipe has room");

  a_e4m3_exp_range: assert property (@(posedge clk) disable iff (rst)
    (v2 && s2.kind == sffc_pkg::K_TO_E4M3 && s2.cls == sffc_pkg::CLS_FIN)
      |-> (s2.exp[7:4] == 4'd0 && s2.exp[3:0] != 4'd0 && s2.exp[3:0] != 4'hF))
    else $error("E4M3 finite exponent out of range");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!v1 && !v2 && !v3))
    else $error("pipe not empty after reset");

endmodule
